@@ hdl/iee_pkg.sv @@
`timescale 1ns / 1ps

package iee_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int DATA_W      = 32;
  localparam int CH_W        = 8;
  localparam int ERR_W       = 3;
  localparam int STEP_W      = $clog2(DATA_W);

  localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CH_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [CH_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [CH_W-1:0] CH_ZERO  = 8'd48;
  localparam logic [CH_W-1:0] CH_NINE  = 8'd57;

  typedef logic signed [DATA_W-1:0] word_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE      = 3'd0,
    ERR_DIV0      = 3'd1,
    ERR_MALFORMED = 3'd2,
    ERR_OVERFLOW  = 3'd3,
    ERR_BADCHAR   = 3'd4
  } err_t;

  typedef enum logic [1:0] {
    SH_HOLD,
    SH_DOWN,
    SH_UP
  } shift_t;

  typedef struct packed {
    shift_t val_sh;
    shift_t op_sh;
  } cell_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OPLOOP,
    ST_REDUCE,
    ST_DIV,
    ST_FLUSH,
    ST_FINISH
  } state_t;

  // Multiplication and division bind tighter than addition and subtraction.
  function automatic logic op_rank(input op_t op);
    return op[1];
  endfunction

endpackage

@@ hdl/iee_cell.sv @@
`timescale 1ns / 1ps

module iee_cell (
  input  logic              clk,
  input  iee_pkg::cell_ctl_t ctl,
  input  iee_pkg::word_t    val_above,
  input  iee_pkg::word_t    val_below,
  input  iee_pkg::op_t      op_above,
  input  iee_pkg::op_t      op_below,
  output iee_pkg::word_t    val,
  output iee_pkg::op_t      op
);
  import iee_pkg::*;

  always_ff @(posedge clk) begin
    case (ctl.val_sh)
      SH_DOWN: val <= val_above;
      SH_UP:   val <= val_below;
      default: val <= val;
    endcase
    case (ctl.op_sh)
      SH_DOWN: op <= op_above;
      SH_UP:   op <= op_below;
      default: op <= op;
    endcase
  end

endmodule

@@ hdl/iee_divider.sv @@
`timescale 1ns / 1ps

module iee_divider (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  iee_pkg::word_t dividend,
  input  iee_pkg::word_t divisor,
  output logic           done,
  output iee_pkg::word_t quotient
);
  import iee_pkg::*;

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] quo;
  logic [DATA_W-1:0] dvs;
  logic              neg;
  logic [DATA_W-1:0] mag_a;
  logic [DATA_W-1:0] mag_b;
  logic [DATA_W:0]   rem_sh;
  logic [DATA_W:0]   diff;

  assign mag_a  = dividend[DATA_W-1] ? (~$unsigned(dividend) + 1'b1) : $unsigned(dividend);
  assign mag_b  = divisor[DATA_W-1] ? (~$unsigned(divisor) + 1'b1) : $unsigned(divisor);
  assign rem_sh = {rem, quo[DATA_W-1]};
  assign diff   = rem_sh - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= !start && busy && (step == '0);
      if (start) begin
        busy <= 1'b1;
      end else if (busy && step == '0) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      step <= STEP_W'(DATA_W - 1);
      rem  <= '0;
      quo  <= mag_a;
      dvs  <= mag_b;
      neg  <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
    end else if (busy) begin
      step <= step - 1'b1;
      if (!diff[DATA_W]) begin
        rem <= diff[DATA_W-1:0];
        quo <= {quo[DATA_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[DATA_W-1:0];
        quo <= {quo[DATA_W-2:0], 1'b0};
      end
    end
  end

  assign quotient = neg ? word_t'(~quo + 1'b1) : word_t'(quo);

endmodule

@@ hdl/infix_expression_evaluator.sv @@
`timescale 1ns / 1ps

// Channel  Direction  Contents
// s_*      in         tdata[7:0] = ch, tlast = last (last character of the expression)
// m_*      out        tdata[31:0] = value, tdata[34:32] = error, tdata[39:35] = 0
//
// A digit or bad character is taken while idle; an operator runs the operator loop and
// a reduce step per reduction; a division waits in the shared bit-serial divider.
// The last character flushes each remaining operator, then the result is emitted.
// Reset clears the counts, the error code and the result valid flag; stack cells keep data.
// The result sits in an output register, so a new expression is taken while it waits.
module infix_expression_evaluator (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  s_tdata,   // ch
  input  logic        s_tlast,
  input  logic        s_tvalid,
  output logic        s_tready,
  output logic [39:0] m_tdata,   // value, error, zero fill
  output logic        m_tvalid,
  input  logic        m_tready
);
  import iee_pkg::*;

  state_t state, state_next;
  cnt_t   vcnt, vcnt_next;
  cnt_t   ocnt, ocnt_next;
  err_t   err, err_next;
  op_t    cur_op, cur_op_next;
  logic   cur_last, cur_last_next;
  logic   flushing, flushing_next;
  logic   out_valid, out_valid_next;
  word_t  out_value, out_value_next;
  err_t   out_err, out_err_next;

  word_t     val_q [STACK_DEPTH];
  op_t       op_q  [STACK_DEPTH];
  cell_ctl_t ctl   [STACK_DEPTH];

  logic  val_push, val_reduce, op_push, op_pop;
  word_t val_in;
  logic  div_start, div_done;
  word_t div_q;
  logic  accept, is_digit, is_op;
  op_t   ch_op;
  word_t alu_res;
  op_t   top_op;

  assign accept   = s_tvalid && s_tready;
  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = out_valid;
  assign m_tdata  = {5'b0, out_err, out_value};
  assign top_op   = op_q[0];
  assign is_digit = (s_tdata >= CH_ZERO) && (s_tdata <= CH_NINE);

  always_comb begin
    is_op = 1'b1;
    ch_op = OP_ADD;
    case (s_tdata)
      CH_PLUS:  ch_op = OP_ADD;
      CH_MINUS: ch_op = OP_SUB;
      CH_STAR:  ch_op = OP_MUL;
      CH_SLASH: ch_op = OP_DIV;
      default:  is_op = 1'b0;
    endcase
  end

  always_comb begin
    case (top_op)
      OP_ADD:  alu_res = val_q[1] + val_q[0];
      OP_SUB:  alu_res = val_q[1] - val_q[0];
      default: alu_res = val_q[1] * val_q[0];
    endcase
  end

  iee_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (val_q[1]),
    .divisor  (val_q[0]),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      vcnt      <= '0;
      ocnt      <= '0;
      err       <= ERR_NONE;
      flushing  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      vcnt      <= vcnt_next;
      ocnt      <= ocnt_next;
      err       <= err_next;
      flushing  <= flushing_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cur_op    <= cur_op_next;
    cur_last  <= cur_last_next;
    out_value <= out_value_next;
    out_err   <= out_err_next;
  end

  always_comb begin
    state_next     = state;
    vcnt_next      = vcnt;
    ocnt_next      = ocnt;
    err_next       = err;
    cur_op_next    = cur_op;
    cur_last_next  = cur_last;
    flushing_next  = flushing;
    out_valid_next = out_valid && !m_tready;
    out_value_next = out_value;
    out_err_next   = out_err;
    val_push       = 1'b0;
    val_reduce     = 1'b0;
    op_push        = 1'b0;
    op_pop         = 1'b0;
    val_in         = alu_res;
    div_start      = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          cur_last_next = s_tlast;
          state_next    = s_tlast ? ST_FLUSH : ST_IDLE;
          if (err == ERR_NONE) begin
            if (is_digit) begin
              if (vcnt == cnt_t'(STACK_DEPTH)) begin
                err_next = ERR_OVERFLOW;
              end else begin
                val_push  = 1'b1;
                val_in    = word_t'(s_tdata - CH_ZERO);
                vcnt_next = vcnt + 1'b1;
              end
            end else if (is_op) begin
              cur_op_next = ch_op;
              state_next  = ST_OPLOOP;
            end else begin
              err_next = ERR_BADCHAR;
            end
          end
        end
      end

      ST_OPLOOP: begin
        if (ocnt != '0 && !(op_rank(cur_op) && !op_rank(top_op))) begin
          state_next = ST_REDUCE;
        end else begin
          state_next = cur_last ? ST_FLUSH : ST_IDLE;
          if (ocnt == cnt_t'(STACK_DEPTH)) begin
            err_next = ERR_OVERFLOW;
          end else begin
            op_push   = 1'b1;
            ocnt_next = ocnt + 1'b1;
          end
        end
      end

      ST_REDUCE: begin
        op_pop    = 1'b1;
        ocnt_next = ocnt - 1'b1;
        if (vcnt < cnt_t'(2)) begin
          err_next   = ERR_MALFORMED;
          state_next = cur_last ? ST_FLUSH : ST_IDLE;
        end else if (top_op == OP_DIV) begin
          if (val_q[0] == '0) begin
            err_next   = ERR_DIV0;
            state_next = cur_last ? ST_FLUSH : ST_IDLE;
          end else begin
            div_start  = 1'b1;
            state_next = ST_DIV;
          end
        end else begin
          val_reduce = 1'b1;
          vcnt_next  = vcnt - 1'b1;
          state_next = flushing ? ST_FLUSH : ST_OPLOOP;
        end
      end

      ST_DIV: begin
        if (div_done) begin
          val_reduce = 1'b1;
          val_in     = div_q;
          vcnt_next  = vcnt - 1'b1;
          state_next = flushing ? ST_FLUSH : ST_OPLOOP;
        end
      end

      ST_FLUSH: begin
        flushing_next = 1'b1;
        if (err == ERR_NONE && ocnt != '0) begin
          state_next = ST_REDUCE;
        end else begin
          state_next = ST_FINISH;
        end
      end

      ST_FINISH: begin
        if (!out_valid || m_tready) begin
          out_valid_next = 1'b1;
          if (err != ERR_NONE) begin
            out_err_next   = err;
            out_value_next = '0;
          end else if (vcnt != cnt_t'(1)) begin
            out_err_next   = ERR_MALFORMED;
            out_value_next = '0;
          end else begin
            out_err_next   = ERR_NONE;
            out_value_next = val_q[0];
          end
          vcnt_next     = '0;
          ocnt_next     = '0;
          err_next      = ERR_NONE;
          flushing_next = 1'b0;
          state_next    = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    word_t val_above, val_below;
    op_t   op_above, op_below;

    if (i == 0) begin : g_top
      assign val_above = val_in;
      assign op_above  = cur_op;
    end else begin : g_mid
      assign val_above = val_q[i-1];
      assign op_above  = op_q[i-1];
    end

    if (i == STACK_DEPTH - 1) begin : g_bot
      assign val_below = '0;
      assign op_below  = OP_ADD;
    end else begin : g_up
      assign val_below = val_q[i+1];
      assign op_below  = op_q[i+1];
    end

    always_comb begin
      if (val_push) begin
        ctl[i].val_sh = SH_DOWN;
      end else if (val_reduce) begin
        ctl[i].val_sh = (i == 0) ? SH_DOWN : SH_UP;
      end else begin
        ctl[i].val_sh = SH_HOLD;
      end
      if (op_push) begin
        ctl[i].op_sh = SH_DOWN;
      end else if (op_pop) begin
        ctl[i].op_sh = SH_UP;
      end else begin
        ctl[i].op_sh = SH_HOLD;
      end
    end

    iee_cell u_cell (
      .clk       (clk),
      .ctl       (ctl[i]),
      .val_above (val_above),
      .val_below (val_below),
      .op_above  (op_above),
      .op_below  (op_below),
      .val       (val_q[i]),
      .op        (op_q[i])
    );
  end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import iee_pkg::*;

  localparam int CLK_PERIOD = 8;
  localparam int RANDOM_ITEMS = 1900;
  localparam int LONG_HOLD = 300;

  typedef struct packed {
    word_t value;
    err_t  error;
  } result_t;

  typedef struct {
    string text;
    bit    typed;
    word_t value;
    err_t  error;
  } directed_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic [7:0]  s_tdata = '0;   // ch
  logic        s_tlast = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] m_tdata;        // value, error, zero fill
  logic        m_tvalid;
  logic        m_tready = 1'b0;

  word_t val_stack[STACK_DEPTH];
  int    val_depth;
  op_t   op_stack[STACK_DEPTH];
  int    op_depth;
  err_t  expr_err;

  result_t    pending_results[$];
  logic [7:0] expr_chars[$];
  int         mismatches;
  int         live_chars;
  int         expressions;
  int         results_seen;
  int         err_seen[5];
  int         hold_request;
  bit         tx_steady;
  bit         rx_steady;

  directed_row_t directed_rows[11] = '{
    '{"0", 1'b1, 32'sd0, ERR_NONE},
    '{"9", 1'b1, 32'sd9, ERR_NONE},
    '{"+", 1'b1, 32'sd0, ERR_MALFORMED},
    '{"12", 1'b1, 32'sd0, ERR_MALFORMED},
    '{"4*", 1'b1, 32'sd0, ERR_MALFORMED},
    '{"7/0", 1'b1, 32'sd0, ERR_DIV0},
    '{"a", 1'b1, 32'sd0, ERR_BADCHAR},
    '{"5/0+a", 1'b1, 32'sd0, ERR_DIV0},
    '{"11111111111111111", 1'b1, 32'sd0, ERR_OVERFLOW},
    '{"9*8-7/2", 1'b0, 32'sd0, ERR_NONE},
    '{"3-8/2*7+1", 1'b0, 32'sd0, ERR_NONE}
  };

  infix_expression_evaluator uut (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic void flag_err(input err_t code);
    if (expr_err == ERR_NONE) expr_err = code;
  endfunction

  function automatic bit reduce_top();
    op_t   op;
    word_t lhs;
    word_t rhs;
    word_t res;
    op = op_stack[op_depth - 1];
    op_depth--;
    if (val_depth < 2) begin
      flag_err(ERR_MALFORMED);
      return 1'b0;
    end
    rhs = val_stack[val_depth - 1];
    lhs = val_stack[val_depth - 2];
    val_depth -= 2;
    case (op)
      OP_ADD: res = lhs + rhs;
      OP_SUB: res = lhs - rhs;
      OP_MUL: res = lhs * rhs;
      default: begin
        if (rhs == 0) begin
          flag_err(ERR_DIV0);
          return 1'b0;
        end
        res = (rhs == -1) ? -lhs : lhs / rhs;
      end
    endcase
    val_stack[val_depth] = res;
    val_depth++;
    return 1'b1;
  endfunction

  function automatic void take_char(input logic [7:0] ch);
    op_t op;
    if (ch >= CH_ZERO && ch <= CH_NINE) begin
      if (val_depth >= STACK_DEPTH) begin
        flag_err(ERR_OVERFLOW);
        return;
      end
      val_stack[val_depth] = {24'd0, ch - CH_ZERO};
      val_depth++;
      return;
    end
    case (ch)
      CH_PLUS:  op = OP_ADD;
      CH_MINUS: op = OP_SUB;
      CH_STAR:  op = OP_MUL;
      CH_SLASH: op = OP_DIV;
      default: begin
        flag_err(ERR_BADCHAR);
        return;
      end
    endcase
    // An incoming operator first folds everything of equal or tighter binding.
    while (op_depth > 0 && op[1] <= op_stack[op_depth - 1][1]) begin
      if (!reduce_top()) return;
    end
    if (op_depth >= STACK_DEPTH) begin
      flag_err(ERR_OVERFLOW);
      return;
    end
    op_stack[op_depth] = op;
    op_depth++;
  endfunction

  function automatic bit evaluate_char(input logic [7:0] ch, input logic last,
                                       output result_t res);
    bit ignored;
    ignored = (expr_err != ERR_NONE);
    if (!ignored) take_char(ch);
    if (!ignored || last) live_chars++;
    res = '{value: '0, error: ERR_NONE};
    if (!last) return 1'b0;
    while (expr_err == ERR_NONE && op_depth > 0) void'(reduce_top());
    if (expr_err == ERR_NONE && val_depth != 1) flag_err(ERR_MALFORMED);
    res.value = (expr_err == ERR_NONE) ? val_stack[0] : '0;
    res.error = expr_err;
    val_depth = 0;
    op_depth = 0;
    expr_err = ERR_NONE;
    return 1'b1;
  endfunction

  function automatic logic [7:0] rand_digit();
    return CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_op();
    case ($urandom_range(0, 3))
      0: return CH_PLUS;
      1: return CH_MINUS;
      2: return CH_STAR;
      default: return CH_SLASH;
    endcase
  endfunction

  function automatic void build_wellformed(input int terms);
    for (int i = 0; i < terms; i++) begin
      if (i > 0) expr_chars.push_back(rand_op());
      expr_chars.push_back(rand_digit());
    end
  endfunction

  function automatic void build_random_expr();
    int kind;
    int len;
    int pos;
    kind = $urandom_range(0, 99);
    expr_chars.delete();
    if (kind < 65) begin
      build_wellformed($urandom_range(0, 3) == 0 ? $urandom_range(5, 9) : $urandom_range(1, 4));
    end else if (kind < 77) begin
      // Long products of large digits can wrap past 32 bits.
      len = $urandom_range(8, 14);
      for (int i = 0; i < len; i++) begin
        if (i > 0) expr_chars.push_back($urandom_range(0, 4) != 0 ? CH_STAR : rand_op());
        expr_chars.push_back(CH_ZERO + 8'($urandom_range(2, 9)));
      end
    end else if (kind < 87) begin
      len = $urandom_range(1, 6);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 1) == 0) expr_chars.push_back(8'($urandom_range(0, 255)));
        else if ($urandom_range(0, 1) == 0) expr_chars.push_back(rand_digit());
        else expr_chars.push_back(rand_op());
      end
    end else if (kind < 96) begin
      build_wellformed($urandom_range(1, 5));
      pos = $urandom_range(0, expr_chars.size());
      case ($urandom_range(0, 3))
        0: expr_chars.insert(pos, rand_digit());
        1: expr_chars.insert(pos, rand_op());
        2: expr_chars.push_front(rand_op());
        default: expr_chars.push_back(rand_op());
      endcase
    end else begin
      len = $urandom_range(STACK_DEPTH - 1, STACK_DEPTH + 2);
      for (int i = 0; i < len; i++) expr_chars.push_back(rand_digit());
    end
  endfunction

  task automatic send_item(input logic [7:0] ch, input logic last, input bit typed,
                           input result_t want);
    int      gap;
    result_t res;
    gap = tx_steady ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tdata <= ch;
    s_tlast <= last;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (s_tready !== 1'b1);
    if (evaluate_char(ch, last, res)) pending_results.push_back(typed ? want : res);
  endtask

  task automatic send_expr(input bit typed, input result_t want);
    foreach (expr_chars[i]) send_item(expr_chars[i], i == expr_chars.size() - 1, typed, want);
    expressions++;
    if ($urandom_range(0, 14) == 0) tx_steady = !tx_steady;
    if ($urandom_range(0, 14) == 0) rx_steady = !rx_steady;
  endtask

  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    result_t want;
    val_depth = 0;
    op_depth = 0;
    expr_err = ERR_NONE;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      expr_chars.delete();
      for (int k = 0; k < directed_rows[i].text.len(); k++) begin
        expr_chars.push_back(directed_rows[i].text[k]);
      end
      want = '{value: directed_rows[i].value, error: directed_rows[i].error};
      send_expr(directed_rows[i].typed, want);
    end
    wait_for_results();

    // The sink holds off while short expressions keep arriving, so the block backs up.
    hold_request = LONG_HOLD;
    tx_steady = 1'b1;
    repeat (10) begin
      expr_chars.delete();
      build_wellformed($urandom_range(1, 3));
      send_expr(1'b0, want);
    end
    wait_for_results();

    tx_steady = 1'b0;
    live_chars = 0;
    while (live_chars < RANDOM_ITEMS) begin
      build_random_expr();
      send_expr(1'b0, want);
      if ($urandom_range(0, 59) == 0) wait_for_results();
    end
    wait_for_results();
    repeat (100) @(posedge clk);

    $display("Checked %0d results from %0d expressions, %0d live characters in random part.",
             results_seen, expressions, live_chars);
    $display("Result codes seen: ok %0d, div0 %0d, malformed %0d, overflow %0d, badchar %0d.",
             err_seen[0], err_seen[1], err_seen[2], err_seen[3], err_seen[4]);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin : result_sink
    int      stall;
    result_t want;
    @(negedge rst);
    forever begin
      if (hold_request > 0) begin
        stall = hold_request;
        hold_request = 0;
      end else begin
        stall = rx_steady ? 0 : $urandom_range(0, 5);
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (m_tvalid !== 1'b1);
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result with no expectation: value %0d error %0d",
               $signed(m_tdata[31:0]), m_tdata[34:32]);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        err_seen[int'(want.error)]++;
        if (m_tdata[31:0] !== want.value) begin
          $error("value: expected %0d, actual %0d", want.value, $signed(m_tdata[31:0]));
          mismatches++;
        end
        if (m_tdata[34:32] !== want.error) begin
          $error("error: expected %0d, actual %0d", want.error, m_tdata[34:32]);
          mismatches++;
        end
        if (m_tdata[39:35] !== 5'd0) begin
          $error("fill: expected 0, actual %0d", m_tdata[39:35]);
          mismatches++;
        end
      end
    end
  end

  initial begin : watchdog
    #10_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/iee_pkg.sv
hdl/iee_cell.sv
hdl/iee_divider.sv
hdl/infix_expression_evaluator.sv
bench/tb.sv
